// File: rtl/gmn_pkg.sv
// Shared types and constants for the gradient magnitude normalizer.
package gmn_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MagW         = 15;
  localparam logic [MagW-1:0] MagOnes  = '1;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       last_pixel;
    logic       no_image;
  } out_item_t;

  // Restoring square root control for the square root unit.
  typedef struct packed {
    logic        start;
    logic [31:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] root;
  } sqrt_rsp_t;

endpackage

// File: rtl/gmn_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module gmn_sqrt
  import gmn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d, val_q, val_d;
  logic [15:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;
  logic [33:0] remsh;

  always_comb begin
    rem_d  = rem_q;
    val_d  = val_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    remsh  = {rem_q, val_q[31:30]};
    trial  = {16'd0, root_q, 2'b01};
    if (req_i.start) begin
      rem_d  = '0;
      val_d  = req_i.radicand;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[29:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = 32'(remsh - trial);
        root_d = {root_q[14:0], 1'b1};
      end else begin
        rem_d  = remsh[31:0];
        root_d = {root_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    val_q  <= val_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q[MagW-1:0];

endmodule

// File: rtl/gradient_magnitude_normalizer_top.sv
// Top level: pixel load, Prewitt magnitude pass and normalized fetch.
// Load: one item per cycle while not busy; the last load starts the magnitude
// pass: per pixel, 9 taps (read, accumulate), root start, 16 root steps, done; busy held.
// Fetch: read, setup, divide, then output state; the strobe follows it, busy held
// until then; with no image, strobe next cycle, busy held while it is up.
// Reset: asynchronous, clears control; memories hold no reset value. Results cannot be held off.
module gradient_magnitude_normalizer_top
  import gmn_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned XW    = $clog2(MaxWidth + 1);
  localparam int unsigned YW    = $clog2(MaxHeight + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RADR  = 9'b000000010,
    ST_RACC  = 9'b000000100,
    ST_SQRT  = 9'b000001000,
    ST_SWAIT = 9'b000010000,
    ST_FRD   = 9'b000100000,
    ST_FSET  = 9'b001000000,
    ST_FDIV  = 9'b010000000,
    ST_FOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]      pix_mem [Depth];
  logic [MagW-1:0] mag_mem [Depth];

  logic [8:0] wreg_q, hreg_q;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [CW-1:0] total;

  always_comb begin
    w_eff = (wreg_q == 9'd0) ? XW'(1) :
            (32'(wreg_q) > MaxWidth) ? XW'(MaxWidth) : XW'(wreg_q);
    h_eff = (hreg_q == 9'd0) ? YW'(1) :
            (32'(hreg_q) > MaxHeight) ? YW'(MaxHeight) : YW'(hreg_q);
  end
  assign total = CW'(w_eff) * CW'(h_eff);

  logic [CW-1:0] load_cnt_q, fetch_cnt_q;
  logic          ready_q;
  logic [MagW-1:0] min_q, max_q;

  // Magnitude pass position.
  logic [XW-1:0] px_q;
  logic [YW-1:0] py_q;
  logic [AW-1:0] paddr_q;
  logic [3:0]    k_q;
  logic          rd_ok_q;
  logic [1:0]    kr_q;
  logic [1:0]    kc_q;
  logic signed [11:0] gx_q, gy_q;
  logic [7:0]    pix_rd_q;
  logic [MagW-1:0] mag_rd_q;

  sqrt_req_t sreq;
  sqrt_rsp_t srsp;

  gmn_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sreq),
    .rsp_o (srsp)
  );

  // Fetch divide: q = ceil(255*d/den), restoring, 8 quotient bits.
  logic [MagW+8:0] num_q;
  logic [MagW+8:0] num_c;
  logic [MagW-1:0] den_q;
  logic [MagW-1:0] d_q;
  logic [MagW:0]   drem_q;
  logic [7:0]      quo_q;
  logic [3:0]      dcnt_q;
  logic            flat_q;
  logic            lastf_q;

  // Numerator 255*d + den - 1.
  assign num_c = {1'b0, d_q, 8'd0} - {9'd0, d_q} + {9'd0, den_q} - (MagW+9)'(1);

  out_item_t out_q;
  logic      outv_q;

  logic accept, is_load, cfg_we;
  assign accept  = start && !busy;
  assign is_load = (in_item_i.func == FUNC_LOAD);
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign busy = (state_q != ST_IDLE) || outv_q;

  // Window tap position.
  logic signed [XW+1:0] tx;
  logic signed [YW+1:0] ty;
  logic tap_in;
  logic [AW-1:0] taddr;
  always_comb begin
    tx = $signed({2'b00, px_q}) + $signed({{XW{1'b0}}, kc_q}) - (XW+2)'(1);
    ty = $signed({2'b00, py_q}) + $signed({{YW{1'b0}}, kr_q}) - (YW+2)'(1);
    tap_in = (tx >= 0) && (ty >= 0) && (tx < $signed({2'b00, w_eff}))
             && (ty < $signed({2'b00, h_eff}));
    // Tap address relative to the center: paddr + dy*w + dx.
    taddr = AW'(paddr_q + (kr_q == 2'd0 ? -AW'(w_eff) :
                           kr_q == 2'd2 ?  AW'(w_eff) : AW'(0))
                        + AW'(kc_q) - AW'(1));
  end

  logic [31:0] sq;
  logic signed [23:0] gx_w, gy_w;
  always_comb begin
    gx_w = 24'(gx_q);
    gy_w = 24'(gy_q);
    sq = 32'(gx_w * gx_w) + 32'(gy_w * gy_w);
    sreq.start    = (state_q == ST_SQRT);
    sreq.radicand = {sq[23:0], 8'd0};
  end

  logic pass_last;
  assign pass_last = (32'(paddr_q) + 32'd1 >= 32'(total));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && !is_load && ready_q) state_d = ST_FRD;
                else if (accept && is_load && !ready_q &&
                         (load_cnt_q + CW'(1) >= total)) state_d = ST_RADR;
                else if (accept && is_load && ready_q && total == CW'(1))
                  state_d = ST_RADR;
      ST_RADR:  state_d = ST_RACC;
      ST_RACC:  state_d = (k_q == 4'd8) ? ST_SQRT : ST_RADR;
      ST_SQRT:  state_d = ST_SWAIT;
      ST_SWAIT: if (srsp.done) state_d = pass_last ? ST_IDLE : ST_RADR;
      ST_FRD:   state_d = ST_FSET;
      ST_FSET:  state_d = ST_FDIV;
      ST_FDIV:  if (dcnt_q == 4'd8) state_d = ST_FOUT;
      ST_FOUT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wreg_q      <= 9'd256;
      hreg_q      <= 9'd256;
      load_cnt_q  <= '0;
      fetch_cnt_q <= '0;
      ready_q     <= 1'b0;
      min_q       <= MagOnes;
      max_q       <= '0;
      outv_q      <= 1'b0;
      k_q         <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      outv_q  <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx_i == REG_WIDTH) wreg_q <= cfg_data_i;
        else                        hreg_q <= cfg_data_i;
        load_cnt_q  <= '0;
        fetch_cnt_q <= '0;
        ready_q     <= 1'b0;
        min_q       <= MagOnes;
        max_q       <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && is_load) begin
            // Load while ready drops the finished image.
            if (ready_q) begin
              fetch_cnt_q <= '0;
              min_q       <= MagOnes;
              max_q       <= '0;
              ready_q     <= (total == CW'(1));
              load_cnt_q  <= CW'(1);
            end else begin
              load_cnt_q <= load_cnt_q + CW'(1);
              if (load_cnt_q + CW'(1) >= total) ready_q <= 1'b1;
            end
            k_q <= '0;
          end else if (accept && !ready_q) begin
            outv_q <= 1'b1;
          end
        end
        ST_RACC: k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
        ST_SWAIT: begin
          if (srsp.done) begin
            if (srsp.root < min_q) min_q <= srsp.root;
            if (srsp.root > max_q) max_q <= srsp.root;
          end
        end
        ST_FSET:  dcnt_q <= '0;
        ST_FDIV:  dcnt_q <= dcnt_q + 4'd1;
        ST_FOUT: begin
          outv_q      <= 1'b1;
          fetch_cnt_q <= fetch_cnt_q + CW'(1);
          if (lastf_q) begin
            fetch_cnt_q <= '0;
            load_cnt_q  <= '0;
            ready_q     <= 1'b0;
            min_q       <= MagOnes;
            max_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && is_load) begin
          pix_mem[ready_q ? AW'(0) : load_cnt_q[AW-1:0]] <= in_item_i.pixel;
        end
        px_q    <= '0;
        py_q    <= '0;
        paddr_q <= '0;
        kr_q    <= '0;
        kc_q    <= '0;
        gx_q    <= '0;
        gy_q    <= '0;
        out_q   <= '{out_pixel: 8'd0, last_pixel: 1'b0, no_image: 1'b1};
      end
      ST_RADR: begin
        pix_rd_q <= pix_mem[taddr];
        rd_ok_q  <= tap_in;
      end
      ST_RACC: begin
        if (rd_ok_q) begin
          if (kc_q == 2'd0) gx_q <= gx_q - $signed({4'd0, pix_rd_q});
          if (kc_q == 2'd2) gx_q <= gx_q + $signed({4'd0, pix_rd_q});
          if (kr_q == 2'd0) gy_q <= gy_q - $signed({4'd0, pix_rd_q});
          if (kr_q == 2'd2) gy_q <= gy_q + $signed({4'd0, pix_rd_q});
        end
        if (kc_q == 2'd2) begin
          kc_q <= '0;
          kr_q <= (kr_q == 2'd2) ? 2'd0 : kr_q + 2'd1;
        end else begin
          kc_q <= kc_q + 2'd1;
        end
      end
      ST_SWAIT: begin
        if (srsp.done) begin
          mag_mem[paddr_q] <= srsp.root;
          paddr_q <= paddr_q + AW'(1);
          gx_q    <= '0;
          gy_q    <= '0;
          if (px_q + XW'(1) == w_eff) begin
            px_q <= '0;
            py_q <= py_q + YW'(1);
          end else begin
            px_q <= px_q + XW'(1);
          end
        end
      end
      ST_FRD: begin
        mag_rd_q <= mag_mem[fetch_cnt_q[AW-1:0]];
        lastf_q  <= (fetch_cnt_q + CW'(1) >= total);
      end
      ST_FSET: begin
        flat_q <= !(max_q > min_q);
        den_q  <= max_q - min_q;
        // Clamp d to [0, den].
        d_q    <= (mag_rd_q <= min_q) ? MagW'(0) :
                  (mag_rd_q > max_q) ? max_q - min_q : mag_rd_q - min_q;
        drem_q <= '0;
        quo_q  <= '0;
      end
      ST_FDIV: begin
        if (dcnt_q == 4'd0) begin
          // Quotient is at most 255: preload the numerator top bits.
          drem_q <= num_c[MagW+8:8];
          num_q  <= num_c;
        end else begin
          if ({drem_q[MagW-1:0], num_q[7]} >= {1'b0, den_q}) begin
            drem_q <= {drem_q[MagW-1:0], num_q[7]} - {1'b0, den_q};
            quo_q  <= {quo_q[6:0], 1'b1};
          end else begin
            drem_q <= {drem_q[MagW-1:0], num_q[7]};
            quo_q  <= {quo_q[6:0], 1'b0};
          end
          num_q <= {num_q[MagW+7:0], 1'b0};
        end
      end
      ST_FOUT: begin
        out_q.out_pixel  <= flat_q ? 8'd255 : 8'd255 - quo_q;
        out_q.last_pixel <= lastf_q;
        out_q.no_image   <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid_o = outv_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/gmn_checker.sv
// Port-level checks for the normalizer, bound to the top level.
module gmn_checker
  import gmn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input out_item_t out_item_o
);

  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("strobe longer than one cycle");

  a_noimg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.no_image |-> out_item_o.out_pixel == 8'd0
    && !out_item_o.last_pixel) else $error("no_image result not cleared");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_item_i.func == FUNC_LOAD |=> !out_valid_o)
    else $error("load produced a result");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_item_i.func == FUNC_FETCH |=> busy)
    else $error("fetch did not hold busy");

endmodule

bind gradient_magnitude_normalizer_top gmn_checker u_gmn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_item_o (out_item_o)
);

// File: tb/testbench.sv
// Self-checking testbench for the gradient magnitude normalizer top level.
module testbench;
  import gmn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 200000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned ItemGoal = 1050;

  typedef struct {
    bit         is_cfg;
    reg_idx_e   idx;
    logic [8:0] data;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } step_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_idx_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  logic       out_valid_o;
  out_item_t  out_item_o;

  gradient_magnitude_normalizer_top uut (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_idx_i, .cfg_data_i, .out_valid_o, .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the normalizer
  logic [7:0]      pix_mem [65536];
  logic [MagW-1:0] mag_mem [65536];
  logic [8:0]      width_reg = 9'd256;
  logic [8:0]      height_reg = 9'd256;
  int unsigned     loaded, fetched;
  logic [MagW-1:0] mag_min = MagOnes, mag_max = '0;
  bit              img_ready;

  out_item_t   pending_px [$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned sent = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    errors++;
    $display("MISMATCH %s: got pix=%0d last=%0b noimg=%0b, want pix=%0d last=%0b noimg=%0b",
             what, got.out_pixel, got.last_pixel, got.no_image,
             want.out_pixel, want.last_pixel, want.no_image);
  endtask

  function automatic int unsigned dim_of(input logic [8:0] v, input int unsigned lim);
    int unsigned d;
    d = (v == 0) ? 1 : v;
    return (d > lim) ? lim : d;
  endfunction

  function automatic int unsigned root_floor(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void restart_image();
    loaded = 0;
    fetched = 0;
    mag_min = MagOnes;
    mag_max = '0;
    img_ready = 0;
  endfunction

  function automatic void prewitt_pass(input int unsigned w, input int unsigned h);
    int gx, gy, yy, xx, p;
    logic [MagW-1:0] m;
    mag_min = MagOnes;
    mag_max = '0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        gx = 0;
        gy = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            yy = y + dy;
            xx = x + dx;
            if (yy >= 0 && yy < h && xx >= 0 && xx < w) begin
              p = pix_mem[yy * w + xx];
              gx += dx * p;
              gy += dy * p;
            end
          end
        end
        m = MagW'(root_floor(longint'(gx * gx + gy * gy) << 8));
        mag_mem[y * w + x] = m;
        if (m < mag_min) mag_min = m;
        if (m > mag_max) mag_max = m;
      end
    end
  endfunction

  // Advance the shadow state by one item; return the result it causes, if any.
  function automatic bit normalize_step(input in_item_t it, output out_item_t r);
    int unsigned w, h, total, den, d, q;
    w = dim_of(width_reg, MaxWidthDef);
    h = dim_of(height_reg, MaxHeightDef);
    total = w * h;
    r = '0;
    if (it.func == FUNC_LOAD) begin
      if (img_ready) restart_image();
      if (loaded < total) begin
        pix_mem[loaded] = it.pixel;
        loaded++;
      end
      if (loaded >= total) begin
        prewitt_pass(w, h);
        fetched = 0;
        img_ready = 1;
      end
      return 0;
    end
    if (!img_ready || fetched >= total) begin
      r.no_image = 1'b1;
      return 1;
    end
    r.out_pixel = 8'd255;
    if (mag_max > mag_min) begin
      den = mag_max - mag_min;
      d = (mag_mem[fetched] > mag_min) ? mag_mem[fetched] - mag_min : 0;
      if (d > den) d = den;
      q = (255 * d + den - 1) / den;
      r.out_pixel = 8'(255 - q);
    end
    fetched++;
    r.last_pixel = (fetched >= total);
    if (fetched >= total) restart_image();
    return 1;
  endfunction

  // Send one item; typed expectation overrides the predicted one when given.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t r;
    bit has;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (busy);
    has = normalize_step(it, r);
    if (has) pending_px.push_back(typed ? want : r);
    sent++;
  endtask

  // Write a register once the block has gone quiet.
  task automatic write_reg(input reg_idx_e idx, input logic [8:0] data);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_WIDTH) width_reg = data;
    else height_reg = data;
    restart_image();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || out_valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (out_valid_o) begin
        if (pending_px.size() == 0) begin
          report("unexpected result", out_item_o, '0);
        end else begin
          want = pending_px.pop_front();
          if (out_item_o.out_pixel != want.out_pixel) report("out_pixel", out_item_o, want);
          if (out_item_o.last_pixel != want.last_pixel) report("last_pixel", out_item_o, want);
          if (out_item_o.no_image != want.no_image) report("no_image", out_item_o, want);
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    step_t steps [$];
    in_item_t it;
    out_item_t none;
    int unsigned img, w, h, total, stop_at, flat_val, r;
    bit flat;

    none = '0;
    for (int i = 0; i < 65536; i++) pix_mem[i] = '0;
    restart_image();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: no image, 2x2 extremes, reload while ready, 1x1 flat image
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_FETCH, 8'd0}, 1, '{8'd0, 1'b0, 1'b1}});
    steps.push_back('{1, REG_WIDTH, 9'd2, '0, 0, none});
    steps.push_back('{1, REG_HEIGHT, 9'd2, '0, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'd0}, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'd255}, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'd255}, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'd0}, 0, none});
    repeat (4) steps.push_back('{0, REG_WIDTH, 0, '{FUNC_FETCH, 8'd0}, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_FETCH, 8'd0}, 1, '{8'd0, 1'b0, 1'b1}});
    for (int v = 10; v <= 40; v += 10)
      steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'(v)}, 0, none});
    for (int v = 7; v <= 10; v++)
      steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'(v)}, 0, none});
    repeat (2) steps.push_back('{0, REG_WIDTH, 0, '{FUNC_FETCH, 8'd0}, 0, none});
    steps.push_back('{1, REG_WIDTH, 9'd0, '0, 0, none});
    steps.push_back('{1, REG_HEIGHT, 9'd0, '0, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_LOAD, 8'd255}, 0, none});
    steps.push_back('{0, REG_WIDTH, 0, '{FUNC_FETCH, 8'd0}, 1, '{8'd255, 1'b1, 1'b0}});

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].idx, steps[i].data);
      else send_item(steps[i].item, steps[i].typed, steps[i].want);
    end

    // Random images: mostly small, a few at the largest extents
    img = 0;
    while (sent < ItemGoal) begin
      case ((img / 4) % 3)
        0: idle_pct = 0;
        1: idle_pct = 80;
        default: idle_pct = 14;
      endcase
      r = $urandom_range(99);
      if (img == 1) begin
        w = 511;
        h = 1;
      end else if (img == 5) begin
        w = 1;
        h = 256;
      end else if (r < 8) begin
        w = 0;
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end
      if (img < 2 || img == 5 || $urandom_range(3) != 0) begin
        write_reg(REG_WIDTH, w[8:0]);
        write_reg(REG_HEIGHT, h[8:0]);
      end
      total = dim_of(width_reg, MaxWidthDef) * dim_of(height_reg, MaxHeightDef);
      flat = ($urandom_range(9) < 2);
      flat_val = $urandom_range(255);
      for (int p = 0; p < total; p++) begin
        if ($urandom_range(99) < 6) send_item('{FUNC_FETCH, 8'($urandom)}, 0, none);
        it.func = FUNC_LOAD;
        r = $urandom_range(9);
        it.pixel = flat ? 8'(flat_val) : (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
        send_item(it, 0, none);
      end
      stop_at = total;
      if (total > 64) stop_at = $urandom_range(10, 30);
      else if ($urandom_range(9) == 0) stop_at = $urandom_range(total);
      for (int f = 0; f < stop_at; f++) send_item('{FUNC_FETCH, 8'($urandom)}, 0, none);
      if ($urandom_range(19) == 0) send_item('{FUNC_FETCH, 8'd0}, 0, none);
      // for one image in seven, hold off until every pending result is back
      if (img % 7 == 3) begin
        @(negedge clk_i);
        start = 1'b0;
        while (pending_px.size() != 0) @(negedge clk_i);
      end
      img++;
    end

    @(negedge clk_i);
    start = 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
